@@ hdl/ssp_pkg.sv @@
// ----------------------------------------------------------------------------
// Shelf strip packer package
// Shared types, codes and constants for the shelf strip packer.
// ----------------------------------------------------------------------------
package ssp_pkg;

   // default shelf store depth
   localparam int MAX_SHELVES_DEF = 64;

   // saturation limit of the 24-bit heights
   localparam logic [23:0] SAT24 = 24'hFFFFFF;

   // reset value of the strip width register
   localparam logic [15:0] STRIP_WIDTH_RST = 16'd1024;

   // register index codes (taken from paddr[2])
   localparam logic REG_STRIP_WIDTH = 1'b0;
   localparam logic REG_FIT_MODE    = 1'b1;

   // shelf selection policy
   typedef enum logic [1:0] {
      FIT_NEXT        = 2'd0,
      FIT_FIRST       = 2'd1,
      FIT_BEST_WIDTH  = 2'd2,
      FIT_BEST_HEIGHT = 2'd3
   } fit_mode_type;

   // result status codes
   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_TOO_WIDE = 2'd1,
      STS_FULL     = 2'd2
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_RDTGT,
      ST_OPEN,
      ST_PLACE,
      ST_DONE
   } ctl_state_type;

   // one shelf record as stored in the shelf memory
   typedef struct packed {
      logic [15:0] fill;
      logic [23:0] base;
      logic [15:0] tall;
   } shelf_ent_type;

   // request to the shelf evaluation unit
   typedef struct packed {
      logic [15:0]   a;
      logic [15:0]   b;
      shelf_ent_type ent;
      logic          orient_en;
      logic          best_height;
   } eval_req_type;

   // answer of the shelf evaluation unit
   typedef struct packed {
      logic        fits;
      logic        swap;
      logic [15:0] ow;
      logic [15:0] oh;
      logic [15:0] score;
   } eval_res_type;

endpackage

@@ hdl/shelf_strip_packer.sv @@
// ----------------------------------------------------------------------------
// Shelf strip packer
// Places rectangles on horizontal shelves of a fixed-width strip.
// ----------------------------------------------------------------------------
// One block word is taken at a time. The shelf records sit in a memory with
// one write and one read port that one evaluation unit reads one record per
// cycle. Next fit looks at the top shelf only. First fit looks at shelves
// up to the first hit and the two best-fit modes at all open shelves, at
// most MAX_SHELVES. A block is handled in the states start, scan, then read
// target or open a new shelf, place and done; a full shelf store goes from
// scan and a block too wide for the strip from start straight to done. The
// scan makes one memory read per shelf. The result word waits in an output
// register, and the next block is taken while it waits, at the earliest in
// the cycle after the result is loaded. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module shelf_strip_packer #(
   parameter int MAX_SHELVES = ssp_pkg::MAX_SHELVES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // block input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_block_id,
   input  logic [15:0] req_block_width,
   input  logic [15:0] req_block_height,
   // placement result
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_placed_id,
   output logic [15:0] rsp_pos_x,
   output logic [23:0] rsp_pos_y,
   output logic        rsp_rotated,
   output logic [23:0] rsp_strip_height,
   output logic [1:0]  rsp_status,
   // configuration
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import ssp_pkg::*;

   localparam int IDX_W = $clog2(MAX_SHELVES);
   localparam int CNT_W = $clog2(MAX_SHELVES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SHELVES);

   // sequencer
   ctl_state_type state_ff, state_in;

   // configuration registers
   logic [15:0]  strip_width_ff, strip_width_in;
   fit_mode_type fit_mode_ff, fit_mode_in;

   // shelf stack state
   logic [CNT_W-1:0] count_ff, count_in;
   logic [23:0]      top_base_ff, top_base_in;
   logic [15:0]      top_tall_ff, top_tall_in;
   logic             shelf0_ok_ff, shelf0_ok_in;

   // working registers of the current block
   logic [15:0]   id_ff, id_in;
   logic [15:0]   cur_w_ff, cur_w_in;
   logic [15:0]   cur_h_ff, cur_h_in;
   logic          flip_ff, flip_in;
   logic [15:0]   px_ff, px_in;
   logic [23:0]   py_ff, py_in;
   status_type    status_ff, status_in;
   logic          found_ff, found_in;
   logic [15:0]   best_ff, best_in;
   logic [IDX_W-1:0] target_ff, target_in;
   logic [IDX_W-1:0] eval_idx_ff, eval_idx_in;
   shelf_ent_type new_ent_ff, new_ent_in;
   logic          use_new_ff, use_new_in;
   logic          rd_zero_ff, rd_zero_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_id_ff, rsp_id_in;
   logic [15:0] rsp_x_ff, rsp_x_in;
   logic [23:0] rsp_y_ff, rsp_y_in;
   logic        rsp_rot_ff, rsp_rot_in;
   logic [23:0] rsp_sh_ff, rsp_sh_in;
   logic [1:0]  rsp_sts_ff, rsp_sts_in;

   // combinational signals
   logic             accept_req;
   logic             cfg_wr;
   logic             out_free;
   logic [24:0]      stack_sum;
   logic [23:0]      stack_top;
   logic [15:0]      min_wh;
   logic             too_wide;
   logic             mode_best;
   logic [IDX_W-1:0] last_idx;
   logic [IDX_W-1:0] ram_rd_addr;
   logic             ram_we;
   shelf_ent_type    ram_wr_data;
   logic [$bits(shelf_ent_type)-1:0] ram_rd_raw;
   shelf_ent_type    entry_rd;
   shelf_ent_type    place_ent;
   logic [15:0]      place_tall;
   eval_req_type     ev_req;
   eval_res_type     ev_res;
   logic             better;
   logic             scan_done;
   logic             scan_found;

   // handshake and shared values
   assign accept_req = req_valid && !req_stall;
   assign cfg_wr     = psel && penable && pwrite;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign stack_sum  = {1'b0, top_base_ff} + {9'b0, top_tall_ff};
   assign stack_top  = stack_sum[24] ? SAT24 : stack_sum[23:0];
   assign min_wh     = (cur_w_ff < cur_h_ff) ? cur_w_ff : cur_h_ff;
   assign too_wide   = min_wh > strip_width_ff;
   assign mode_best  = fit_mode_ff[1];
   assign last_idx   = IDX_W'(count_ff - 1'b1);

   // shelf 0 reads as empty until it is first written
   assign entry_rd  = rd_zero_ff ? '0 : shelf_ent_type'(ram_rd_raw);
   assign place_ent = use_new_ff ? new_ent_ff : entry_rd;
   assign place_tall = (ev_res.oh > place_ent.tall) ? ev_res.oh : place_ent.tall;

   // scan decisions
   assign better     = !found_ff || (ev_res.score < best_ff);
   assign scan_found = found_ff || ev_res.fits;
   assign scan_done  = (eval_idx_ff == last_idx) || (!mode_best && ev_res.fits);

   // shelf record memory
   ssp_ram #(
      .WIDTH ($bits(shelf_ent_type)),
      .DEPTH (MAX_SHELVES)
   ) u_shelf_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (target_ff),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );

   // shared shelf evaluation unit
   ssp_eval u_eval (
      .strip_width (strip_width_ff),
      .ev_req      (ev_req),
      .ev_res      (ev_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept_req) state_in = ST_START;
         end
         ST_START: begin
            state_in = too_wide ? ST_DONE : ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done) begin
               priority if (scan_found) state_in = ST_RDTGT;
               else if (count_ff == CNT_MAX) state_in = ST_DONE;
               else state_in = ST_OPEN;
            end
         end
         ST_RDTGT: state_in = ST_PLACE;
         ST_OPEN:  state_in = ST_PLACE;
         ST_PLACE: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: memory port and evaluation unit inputs
   always_comb begin
      req_stall   = 1'b1;
      ram_rd_addr = target_ff;
      ram_we      = 1'b0;
      ram_wr_data.fill = place_ent.fill + ev_res.ow;
      ram_wr_data.base = place_ent.base;
      ram_wr_data.tall = place_tall;
      ev_req.a           = cur_w_ff;
      ev_req.b           = cur_h_ff;
      ev_req.ent         = entry_rd;
      ev_req.orient_en   = mode_best;
      ev_req.best_height = (fit_mode_ff == FIT_BEST_HEIGHT);
      unique case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_START: begin
            ram_rd_addr = (fit_mode_ff == FIT_NEXT) ? last_idx : '0;
         end
         ST_SCAN: begin
            ram_rd_addr = eval_idx_ff + 1'b1;
         end
         ST_PLACE: begin
            ev_req.ent       = place_ent;
            ev_req.orient_en = 1'b1;
            ram_we           = 1'b1;
         end
         ST_RDTGT, ST_OPEN, ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      strip_width_in = strip_width_ff;
      fit_mode_in    = fit_mode_ff;
      count_in       = count_ff;
      top_base_in    = top_base_ff;
      top_tall_in    = top_tall_ff;
      shelf0_ok_in   = shelf0_ok_ff;
      id_in          = id_ff;
      cur_w_in       = cur_w_ff;
      cur_h_in       = cur_h_ff;
      flip_in        = flip_ff;
      px_in          = px_ff;
      py_in          = py_ff;
      status_in      = status_ff;
      found_in       = found_ff;
      best_in        = best_ff;
      target_in      = target_ff;
      eval_idx_in    = eval_idx_ff;
      new_ent_in     = new_ent_ff;
      use_new_in     = use_new_ff;
      rd_zero_in     = (ram_rd_addr == '0) && !shelf0_ok_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_id_in      = rsp_id_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_rot_in     = rsp_rot_ff;
      rsp_sh_in      = rsp_sh_ff;
      rsp_sts_in     = rsp_sts_ff;

      // register writes, decoded on the word address bit
      if (cfg_wr) begin
         if (paddr[2] == REG_FIT_MODE) begin
            fit_mode_in = fit_mode_type'(pwdata[1:0]);
         end else begin
            strip_width_in = pwdata[15:0];
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept_req) begin
               id_in     = req_block_id;
               cur_w_in  = req_block_width;
               cur_h_in  = req_block_height;
               flip_in   = 1'b0;
               px_in     = '0;
               py_in     = '0;
               status_in = STS_OK;
               found_in  = 1'b0;
               best_in   = '0;
            end
         end
         ST_START: begin
            eval_idx_in = (fit_mode_ff == FIT_NEXT) ? last_idx : '0;
            if (too_wide) status_in = STS_TOO_WIDE;
         end
         ST_SCAN: begin
            // best-fit modes carry the orientation from shelf to shelf
            if (mode_best) begin
               cur_w_in = ev_res.ow;
               cur_h_in = ev_res.oh;
               flip_in  = flip_ff ^ ev_res.swap;
               if (ev_res.fits && better) begin
                  best_in   = ev_res.score;
                  target_in = eval_idx_ff;
                  found_in  = 1'b1;
               end
            end else if (ev_res.fits) begin
               target_in = eval_idx_ff;
               found_in  = 1'b1;
            end
            eval_idx_in = eval_idx_ff + 1'b1;
            if (scan_done && !scan_found && (count_ff == CNT_MAX)) begin
               status_in = STS_FULL;
               flip_in   = 1'b0;
            end
         end
         ST_RDTGT: begin
            use_new_in = 1'b0;
         end
         ST_OPEN: begin
            // new shelf on top, height is the shorter side
            new_ent_in.fill = '0;
            new_ent_in.base = stack_top;
            new_ent_in.tall = min_wh;
            top_base_in     = stack_top;
            top_tall_in     = min_wh;
            count_in        = count_ff + 1'b1;
            target_in       = count_ff[IDX_W-1:0];
            use_new_in      = 1'b1;
         end
         ST_PLACE: begin
            px_in   = place_ent.fill;
            py_in   = place_ent.base;
            flip_in = flip_ff ^ ev_res.swap;
            if (target_ff == '0) shelf0_ok_in = 1'b1;
            if (target_ff == last_idx) top_tall_in = place_tall;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = id_ff;
               rsp_x_in     = px_ff;
               rsp_y_in     = py_ff;
               rsp_rot_in   = flip_ff;
               rsp_sh_in    = stack_top;
               rsp_sts_in   = status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         strip_width_ff <= STRIP_WIDTH_RST;
         fit_mode_ff    <= FIT_NEXT;
         count_ff       <= CNT_W'(1);
         top_base_ff    <= '0;
         top_tall_ff    <= '0;
         shelf0_ok_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         strip_width_ff <= strip_width_in;
         fit_mode_ff    <= fit_mode_in;
         count_ff       <= count_in;
         top_base_ff    <= top_base_in;
         top_tall_ff    <= top_tall_in;
         shelf0_ok_ff   <= shelf0_ok_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      id_ff       <= id_in;
      cur_w_ff    <= cur_w_in;
      cur_h_ff    <= cur_h_in;
      flip_ff     <= flip_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      best_ff     <= best_in;
      target_ff   <= target_in;
      eval_idx_ff <= eval_idx_in;
      new_ent_ff  <= new_ent_in;
      use_new_ff  <= use_new_in;
      rd_zero_ff  <= rd_zero_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_rot_ff  <= rsp_rot_in;
      rsp_sh_ff   <= rsp_sh_in;
      rsp_sts_ff  <= rsp_sts_in;
   end

   // ports
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_placed_id    = rsp_id_ff;
   assign rsp_pos_x        = rsp_x_ff;
   assign rsp_pos_y        = rsp_y_ff;
   assign rsp_rotated      = rsp_rot_ff;
   assign rsp_strip_height = rsp_sh_ff;
   assign rsp_status       = rsp_sts_ff;
   assign pready           = 1'b1;
   assign prdata = (paddr[2] == REG_FIT_MODE) ? {30'b0, fit_mode_ff} : {16'b0, strip_width_ff};

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) && (count_ff <= CNT_MAX))
      else $error("shelf count out of range");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && (status_ff == STS_FULL) |-> count_ff == CNT_MAX)
      else $error("store full reported with free shelves");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept_req |=> state_ff == ST_START)
      else $error("accepted word did not start the sequencer");

   a_open_grows: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OPEN |=>
         (top_base_ff >= $past(top_base_ff)) && (count_ff == $past(count_ff) + 1'b1))
      else $error("new shelf did not stack upward");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STS_OK) |->
         !rsp_rotated && (rsp_pos_x == '0) && (rsp_pos_y == '0))
      else $error("error word carries a position");

endmodule

@@ hdl/ssp_ram.sv @@
// ----------------------------------------------------------------------------
// Shelf strip packer RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module ssp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/ssp_eval.sv @@
// ----------------------------------------------------------------------------
// Shelf strip packer shelf evaluation unit
// Orientation, fit test and score of one block against one shelf record.
// ----------------------------------------------------------------------------
module ssp_eval (
   input  logic [15:0]          strip_width,
   input  ssp_pkg::eval_req_type ev_req,
   output ssp_pkg::eval_res_type ev_res
);
   import ssp_pkg::*;

   logic signed [16:0] room;
   logic signed [16:0] a_s;
   logic signed [16:0] b_s;
   logic               a_gt_room;
   logic               b_gt_room;
   logic               a_gt_b;
   logic               a_lt_b;
   logic [15:0]        t;
   logic [15:0]        big;
   logic               swap;
   logic [15:0]        ow;
   logic [15:0]        oh;

   // free room on the shelf, negative when the strip shrank below the fill
   assign room = $signed({1'b0, strip_width}) - $signed({1'b0, ev_req.ent.fill});
   assign a_s  = $signed({1'b0, ev_req.a});
   assign b_s  = $signed({1'b0, ev_req.b});
   assign t    = ev_req.ent.tall;

   assign a_gt_room = a_s > room;
   assign b_gt_room = b_s > room;
   assign a_gt_b    = ev_req.a > ev_req.b;
   assign a_lt_b    = ev_req.a < ev_req.b;
   assign big       = a_gt_b ? ev_req.a : ev_req.b;

   // rotation rules: lay flat unless too wide, stand up to fill a tall shelf
   assign swap = ev_req.orient_en &&
                 ((a_gt_b && a_gt_room) || (a_gt_b && (ev_req.a < t)) ||
                  (a_lt_b && (ev_req.b > t) && !b_gt_room));
   assign ow = swap ? ev_req.b : ev_req.a;
   assign oh = swap ? ev_req.a : ev_req.b;

   // fit test is symmetric in the two sides, so orientation does not matter
   always_comb begin
      ev_res.fits = (!a_gt_room && !b_gt_room) ||
                    (!(a_gt_room && b_gt_room) && (big <= t));
      ev_res.swap = swap;
      ev_res.ow   = ow;
      ev_res.oh   = oh;
      if (ev_req.best_height) begin
         ev_res.score = (oh < t) ? (t - oh) : 16'd0;
      end else begin
         ev_res.score = room[15:0];
      end
   end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// Shelf strip packer testbench
// Feeds block words to the packer while idling and stalling both channels at
// random. A shelf predictor in the bench computes each placement, and every
// result word is checked field by field against it or a typed row's want.
// A directed table runs first, then random phases over widths and fit modes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import ssp_pkg::*;

   localparam int          SHELF_SLOTS      = MAX_SHELVES_DEF;
   localparam logic [2:0]  ADDR_STRIP_WIDTH = {REG_STRIP_WIDTH, 2'b00};
   localparam logic [2:0]  ADDR_FIT_MODE    = {REG_FIT_MODE, 2'b00};
   localparam int          HOLD_AT          = 370;
   localparam int          HOLD_CYCLES      = 300;
   localparam int          PHASES           = 12;

   // random phase plan: width, mode and block count per phase
   localparam logic [0:PHASES-1][15:0] PHASE_WIDTHS = {
      16'd1024, 16'd1024, 16'd2048, 16'd4096, 16'd300, 16'd65535,
      16'd16, 16'd65535, 16'd1, 16'd700, 16'd65535, 16'd5000};
   localparam logic [0:PHASES-1][1:0] PHASE_MODES = {
      FIT_NEXT, FIT_FIRST, FIT_BEST_WIDTH, FIT_BEST_HEIGHT, FIT_FIRST, FIT_NEXT,
      FIT_BEST_WIDTH, FIT_BEST_HEIGHT, FIT_FIRST, FIT_BEST_HEIGHT, FIT_BEST_WIDTH,
      FIT_NEXT};
   localparam logic [0:PHASES-1][7:0] PHASE_BLOCKS = {
      8'd100, 8'd100, 8'd100, 8'd100, 8'd80, 8'd100,
      8'd80, 8'd100, 8'd60, 8'd90, 8'd100, 8'd90};

   // one expected placement word
   typedef struct packed {
      logic [15:0] id;
      logic [15:0] x;
      logic [23:0] y;
      logic        rot;
      logic [23:0] height;
      status_type  status;
   } placement_type;

   // one row of the directed script: a register write or a block word
   typedef struct packed {
      logic          is_cfg;
      logic [2:0]    addr;
      logic [31:0]   data;
      logic [15:0]   id;
      logic [15:0]   w;
      logic [15:0]   h;
      logic          typed;
      placement_type want;
   } step_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_block_id;
   logic [15:0] req_block_width;
   logic [15:0] req_block_height;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_placed_id;
   logic [15:0] rsp_pos_x;
   logic [23:0] rsp_pos_y;
   logic        rsp_rotated;
   logic [23:0] rsp_strip_height;
   logic [1:0]  rsp_status;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // shelf predictor state
   logic [31:0]   shelf_fill [SHELF_SLOTS];
   logic [31:0]   shelf_base [SHELF_SLOTS];
   logic [31:0]   shelf_tall [SHELF_SLOTS];
   int unsigned   shelf_total;
   logic [31:0]   top_y;
   logic [15:0]   cur_width;
   fit_mode_type  cur_mode;

   placement_type placements_due[$];
   step_row_type  script[$];
   int unsigned   mismatches;
   bit            sender_gaps;
   bit            rcv_gaps;

   shelf_strip_packer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_block_id     (req_block_id),
      .req_block_width  (req_block_width),
      .req_block_height (req_block_height),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_placed_id    (rsp_placed_id),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_rotated      (rsp_rotated),
      .rsp_strip_height (rsp_strip_height),
      .rsp_status       (rsp_status),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #8ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------------
   // shelf predictor
   // ---------------------------------------------------------------------
   function automatic longint room_left(int j);
      return longint'(cur_width) - longint'(shelf_fill[j]);
   endfunction

   function automatic bit fits_on(int j, longint w, longint h);
      longint room;
      longint big;
      room = room_left(j);
      big  = (w > h) ? w : h;
      if (w <= room && h <= room) return 1'b1;
      return !(w > room && h > room) && big <= longint'(shelf_tall[j]);
   endfunction

   // shelf rotation rule for orientation (a, b) on shelf j
   function automatic bit wants_turn(int j, longint a, longint b);
      longint room;
      longint t;
      room = room_left(j);
      t    = longint'(shelf_tall[j]);
      return (a > b && a > room) || (a > b && a < t) || (a < b && b > t && b <= room);
   endfunction

   function automatic placement_type place_block(logic [15:0] id, logic [15:0] bw,
                                                 logic [15:0] bh);
      placement_type r;
      longint        w, h, t, best, score;
      int            j, target;
      bit            found, flip;
      logic [31:0]   nb, sh;
      w      = bw;
      h      = bh;
      flip   = 1'b0;
      found  = 1'b0;
      target = 0;
      best   = 0;
      r.id   = id;
      r.x    = '0;
      r.y    = '0;
      r.status = STS_OK;
      if (((w < h) ? w : h) > longint'(cur_width)) begin
         r.status = STS_TOO_WIDE;
      end else begin
         // shelf selection
         case (cur_mode)
            FIT_NEXT: begin
               target = shelf_total - 1;
               found  = fits_on(target, w, h);
            end
            FIT_FIRST: begin
               for (j = 0; j < shelf_total && !found; j++) begin
                  if (fits_on(j, w, h)) begin
                     found  = 1'b1;
                     target = j;
                  end
               end
            end
            default: begin
               // orientation carries from shelf to shelf
               for (j = 0; j < shelf_total; j++) begin
                  if (wants_turn(j, w, h)) begin
                     t = w; w = h; h = t;
                     flip = ~flip;
                  end
                  if (fits_on(j, w, h)) begin
                     if (cur_mode == FIT_BEST_WIDTH) begin
                        score = room_left(j);
                     end else begin
                        score = longint'(shelf_tall[j]) - h;
                        if (score < 0) score = 0;
                     end
                     if (!found || score < best) begin
                        best   = score;
                        target = j;
                        found  = 1'b1;
                     end
                  end
               end
            end
         endcase
         if (!found && shelf_total >= SHELF_SLOTS) begin
            r.status = STS_FULL;
            flip     = 1'b0;
         end else begin
            // new shelf on the block's short side
            if (!found) begin
               target = shelf_total;
               nb     = top_y + shelf_tall[shelf_total - 1];
               top_y  = (nb > SAT24) ? 32'(SAT24) : nb;
               shelf_fill[target] = '0;
               shelf_base[target] = top_y;
               shelf_tall[target] = 32'(((w < h) ? w : h) & 32'hFFFF);
               shelf_total++;
            end
            if (wants_turn(target, w, h)) begin
               t = w; w = h; h = t;
               flip = ~flip;
            end
            r.x = shelf_fill[target][15:0];
            r.y = shelf_base[target][23:0];
            shelf_fill[target] = 32'((longint'(shelf_fill[target]) + w) & 32'hFFFF);
            if (h > longint'(shelf_tall[target])) shelf_tall[target] = 32'(h & 32'hFFFF);
         end
      end
      sh = top_y + shelf_tall[shelf_total - 1];
      if (sh > SAT24) sh = 32'(SAT24);
      r.rot    = flip;
      r.height = sh[23:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------
   task automatic flag(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: %s got %0h want %0h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic check_result();
      placement_type want;
      if (placements_due.size() == 0) begin
         flag("result word with nothing pending, id", rsp_placed_id, 32'd0);
      end else begin
         want = placements_due.pop_front();
         if (rsp_placed_id !== want.id) flag("placed_id", rsp_placed_id, want.id);
         if (rsp_pos_x !== want.x) flag("pos_x", rsp_pos_x, want.x);
         if (rsp_pos_y !== want.y) flag("pos_y", rsp_pos_y, want.y);
         if (rsp_rotated !== want.rot) flag("rotated", rsp_rotated, want.rot);
         if (rsp_strip_height !== want.height)
            flag("strip_height", rsp_strip_height, want.height);
         if (rsp_status !== want.status) flag("status", rsp_status, want.status);
      end
   endtask

   // ---------------------------------------------------------------------
   // driving
   // ---------------------------------------------------------------------
   task automatic send_block(logic [15:0] id, logic [15:0] w, logic [15:0] h,
                             logic typed, placement_type want);
      int unsigned   gap;
      placement_type got;
      gap = sender_gaps ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_block_id     <= id;
      req_block_width  <= w;
      req_block_height <= h;
      do @(posedge clock); while (req_stall !== 1'b0);
      got = place_block(id, w, h);
      placements_due = {placements_due, (typed ? want : got)};
   endtask

   // hold off new words until every placement is back
   task automatic wait_all_placed();
      req_valid <= 1'b0;
      while (placements_due.size() != 0) @(posedge clock);
   endtask

   // register write, then read back
   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (addr == ADDR_STRIP_WIDTH) cur_width = data[15:0];
      else cur_mode = fit_mode_type'(data[1:0]);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (addr == ADDR_STRIP_WIDTH) begin
         if (prdata[15:0] !== data[15:0]) flag("strip_width readback", prdata, data);
      end else begin
         if (prdata[1:0] !== data[1:0]) flag("fit_mode readback", prdata, data);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // directed script rows
   // ---------------------------------------------------------------------
   function automatic step_row_type cfg_row(logic [2:0] addr, logic [31:0] data);
      step_row_type s;
      s        = '0;
      s.is_cfg = 1'b1;
      s.addr   = addr;
      s.data   = data;
      return s;
   endfunction

   function automatic step_row_type item_row(logic [15:0] id, logic [15:0] w,
                                             logic [15:0] h);
      step_row_type s;
      s    = '0;
      s.id = id;
      s.w  = w;
      s.h  = h;
      return s;
   endfunction

   function automatic step_row_type typed_row(logic [15:0] id, logic [15:0] w,
                                              logic [15:0] h, logic [23:0] height,
                                              status_type st);
      step_row_type s;
      s             = item_row(id, w, h);
      s.typed       = 1'b1;
      s.want        = '0;
      s.want.id     = id;
      s.want.height = height;
      s.want.status = st;
      return s;
   endfunction

   // append one row to the directed script
   task automatic add_row(step_row_type s);
      script = {script, s};
   endtask

   // ---------------------------------------------------------------------
   // result side: random stalls, one long hold-off
   // ---------------------------------------------------------------------
   initial begin : result_sink
      int unsigned gap;
      int unsigned seen;
      seen = 0;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (seen == HOLD_AT) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (seen % 64 == 0) rcv_gaps = ($urandom_range(0, 2) != 0);
            gap = rcv_gaps ? $urandom_range(0, 4) : 0;
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         check_result();
         seen++;
      end
   end

   // ---------------------------------------------------------------------
   // block side: directed script, then random phases
   // ---------------------------------------------------------------------
   initial begin : block_source
      step_row_type  row;
      int            p, n, roll;
      int unsigned   lim, short_lim;
      logic [15:0]   w, h, t;
      req_valid        <= 1'b0;
      req_block_id     <= '0;
      req_block_width  <= '0;
      req_block_height <= '0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      reset            <= 1'b1;
      mismatches  = 0;
      sender_gaps = 1'b1;
      foreach (shelf_fill[j]) begin
         shelf_fill[j] = '0;
         shelf_base[j] = '0;
         shelf_tall[j] = '0;
      end
      shelf_total = 1;
      top_y       = '0;
      cur_width   = STRIP_WIDTH_RST;
      cur_mode    = FIT_NEXT;

      // after reset, extremes, every mode, shrunk and widest strip
      add_row(typed_row(16'hFFFF, 16'd1, 16'd1, 24'd1, STS_OK));
      add_row(typed_row(16'h8001, 16'hFFFF, 16'hFFFF, 24'd1, STS_TOO_WIDE));
      add_row(typed_row(16'h0000, 16'd1025, 16'd2000, 24'd1, STS_TOO_WIDE));
      add_row(item_row(16'h0003, 16'hFFFF, 16'd1));
      add_row(item_row(16'h0004, 16'd1024, 16'd1024));
      add_row(item_row(16'h0005, 16'd1, 16'd1024));
      add_row(item_row(16'h0006, 16'd1024, 16'd1));
      add_row(cfg_row(ADDR_FIT_MODE, {30'd0, FIT_FIRST}));
      add_row(item_row(16'h0007, 16'd10, 16'd20));
      add_row(item_row(16'h0008, 16'd20, 16'd10));
      add_row(item_row(16'h0009, 16'd300, 16'd5));
      add_row(cfg_row(ADDR_FIT_MODE, {30'd0, FIT_BEST_WIDTH}));
      add_row(item_row(16'h000A, 16'd10, 16'd20));
      add_row(item_row(16'h000B, 16'd5, 16'd900));
      add_row(cfg_row(ADDR_FIT_MODE, {30'd0, FIT_BEST_HEIGHT}));
      add_row(item_row(16'h000C, 16'd30, 16'd7));
      add_row(item_row(16'h000D, 16'd7, 16'd30));
      add_row(cfg_row(ADDR_STRIP_WIDTH, 32'd1));
      add_row(item_row(16'h000E, 16'd1, 16'd1));
      add_row(item_row(16'h000F, 16'd2, 16'd1));
      add_row(cfg_row(ADDR_STRIP_WIDTH, 32'd65535));
      add_row(item_row(16'h5555, 16'hFFFF, 16'd1));
      add_row(item_row(16'hAAAA, 16'd1, 16'hFFFF));
      add_row(item_row(16'h7FFF, 16'hFFFF, 16'hFFFF));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         row = script[i];
         if (row.is_cfg) begin
            wait_all_placed();
            csr_write(row.addr, row.data);
         end else begin
            send_block(row.id, row.w, row.h, row.typed, row.want);
         end
      end

      // random phases, registers changed only with the block idle
      for (p = 0; p < PHASES; p++) begin
         wait_all_placed();
         csr_write(ADDR_STRIP_WIDTH, {16'd0, PHASE_WIDTHS[p]});
         csr_write(ADDR_FIT_MODE, {30'd0, PHASE_MODES[p]});
         sender_gaps = (p % 3 != 1);
         lim       = cur_width;
         short_lim = (lim / 8 > 0) ? lim / 8 : 1;
         for (n = 0; n < PHASE_BLOCKS[p]; n++) begin
            if (p == 2 && n == 50) wait_all_placed();
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
               // mostly blocks that pack several to a shelf
               w = 16'($urandom_range(1, short_lim));
               h = 16'($urandom_range(1, short_lim));
            end else if (roll < 80) begin
               w = 16'($urandom_range(1, lim));
               h = 16'($urandom_range(1, lim));
            end else if (roll < 88 && lim < 65535) begin
               // one side longer than the strip
               w = 16'($urandom_range(lim + 1, 65535));
               h = 16'($urandom_range(1, short_lim));
               if ($urandom_range(0, 1) == 1) begin
                  t = w; w = h; h = t;
               end
            end else if (roll < 94 && lim < 65535) begin
               w = 16'($urandom_range(lim + 1, 65535));
               h = 16'($urandom_range(lim + 1, 65535));
            end else begin
               w = 16'($urandom_range(1, 65535));
               h = 16'($urandom_range(1, 65535));
            end
            send_block(16'($urandom_range(0, 65535)), w, h, 1'b0, '0);
         end
      end

      // drain and let the block settle
      wait_all_placed();
      repeat (100) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ shelf_strip_packer.f @@
hdl/ssp_pkg.sv
hdl/ssp_ram.sv
hdl/ssp_eval.sv
hdl/shelf_strip_packer.sv
verif/tb.sv
